>>> hdl/m2a_pkg.sv
// Shared types and constants for the 2x2 matrix accumulator unit.
// Holds the request and result word layouts, the action codes and the lane status bundle.
// Depends on nothing; every other file takes its names from here by scope.
`default_nettype none

package m2a_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MUL_CHUNK     = 16;

    typedef enum logic [2:0] {
        ACT_LOAD  = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_SUB   = 3'd2,
        ACT_SCALE = 3'd3,
        ACT_MUL   = 3'd4,
        ACT_INV   = 3'd5
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] b_r0c0;
        logic signed [31:0] b_r0c1;
        logic signed [31:0] b_r1c0;
        logic signed [31:0] b_r1c1;
        logic signed [31:0] scale_factor;
    } op_t;

    typedef struct packed {
        logic signed [31:0] r_r0c0;
        logic signed [31:0] r_r0c1;
        logic signed [31:0] r_r1c0;
        logic signed [31:0] r_r1c1;
        logic               saturated;
        logic               singular;
    } res_t;

    typedef struct packed {
        logic done;
        logic clip;
        logic sing;
    } lane_stat_t;

endpackage

`default_nettype wire

>>> hdl/m2a_lane.sv
// One element lane: a chunked multiplier with a two-term accumulator, a restoring divider
// and the saturation logic that produce one element of the updated matrix.
// Depends on m2a_pkg for the action codes, the multiplier chunk size and the status bundle.
`default_nettype none

module m2a_lane #(
    parameter int WORD_BITS = m2a_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = m2a_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             act,
    input  logic [WORD_BITS-1:0]   a,
    input  logic [WORD_BITS-1:0]   b,
    input  logic [WORD_BITS-1:0]   x0,
    input  logic [WORD_BITS-1:0]   y0,
    input  logic [WORD_BITS-1:0]   x1,
    input  logic [WORD_BITS-1:0]   y1,
    input  logic                   sub,
    input  logic [WORD_BITS-1:0]   src,
    input  logic                   src_neg,
    input  logic                   opclip,
    input  logic                   commit,
    output logic [WORD_BITS-1:0]   val,
    output m2a_pkg::lane_stat_t    stat
);

    localparam int CHUNK = m2a_pkg::MUL_CHUNK;
    localparam int NCH   = (WORD_BITS + CHUNK - 1) / CHUNK;
    localparam int TW    = NCH * CHUNK;
    localparam int MW    = WORD_BITS + TW;
    localparam int PW    = 2 * WORD_BITS;
    localparam int SW    = PW + 1;
    localparam int NUM_W = WORD_BITS + 2 * FRAC_BITS;
    localparam int REM_W = PW + 1;
    localparam int LHS_W = NUM_W + 1;
    localparam int RHS_W = PW + WORD_BITS + 1;
    localparam int CMP_W = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;
    localparam int CNT_W = $clog2(WORD_BITS);

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NCH - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_BITS - 1);

    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN =
        {{(SW - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_EVAL = 7'b0000100,
        ST_CMP  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_RND  = 7'b0100000,
        ST_DONE = 7'b1000000
    } lane_state_t;

    function automatic logic [WORD_BITS:0] sat_word(input logic signed [SW-1:0] v);
        logic [WORD_BITS:0] r;
        if (v > SAT_MAX)
        begin
            r = {1'b1, W_MAX};
        end
        else if (v < SAT_MIN)
        begin
            r = {1'b1, W_MIN};
        end
        else
        begin
            r = {1'b0, v[WORD_BITS-1:0]};
        end
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? -v : v;
    endfunction

    lane_state_t state_reg, state_next;

    logic [2:0]              act_reg;
    logic [WORD_BITS-1:0]    a_reg, b_reg, x1_reg, y1_reg, srcmag_reg;
    logic                    neg1_reg, srcneg_reg, opclip_reg;
    logic [WORD_BITS-1:0]    mcand_reg;
    logic [TW-1:0]           mplier_reg;
    logic [MW-1:0]           macc_reg, macc_next;
    logic                    pneg_reg, second_reg;
    logic signed [SW-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [PW-1:0]           dmag_reg, dmag_c;
    logic                    qneg_reg;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [WORD_BITS-1:0]    qn_reg, qn_next;
    logic [WORD_BITS-1:0]    res_reg;
    logic                    clip_reg, sing_reg;

    logic [WORD_BITS+CHUNK-1:0] partial;
    logic [PW-1:0]              prod;
    logic signed [SW-1:0]       prod_s, term, add_sum, rnd, det_abs;
    logic [WORD_BITS:0]         sat_add, sat_rnd;
    logic [NUM_W-1:0]           num;
    logic [CMP_W-1:0]           lhs, rhs_base, rhs;
    logic                       too_big;
    logic [REM_W-1:0]           r2, dcmp;
    logic                       ge, round_up;
    logic [WORD_BITS-1:0]       qr;

    assign partial   = mcand_reg * mplier_reg[CHUNK-1:0];
    assign macc_next = (macc_reg >> CHUNK) + (MW'(partial) << (TW - CHUNK));
    assign prod      = macc_next[PW-1:0];
    assign prod_s    = $signed({1'b0, prod});
    assign term      = pneg_reg ? -prod_s : prod_s;
    assign sum_next  = sum_reg + term;

    assign add_sum = (act_reg == m2a_pkg::ACT_SUB)
                   ? SW'($signed(a_reg)) - SW'($signed(b_reg))
                   : SW'($signed(a_reg)) + SW'($signed(b_reg));
    assign rnd     = (sum_reg + HALF) >>> FRAC_BITS;
    assign sat_add = sat_word(add_sum);
    assign sat_rnd = sat_word(rnd);

    assign det_abs = sum_reg[SW-1] ? -sum_reg : sum_reg;
    assign dmag_c  = det_abs[PW-1:0];

    assign num      = {srcmag_reg, {(2 * FRAC_BITS){1'b0}}};
    assign lhs      = CMP_W'(num) << 1;
    assign rhs_base = CMP_W'(dmag_reg) << WORD_BITS;
    assign rhs      = qneg_reg ? rhs_base + CMP_W'(dmag_reg) : rhs_base - CMP_W'(dmag_reg);
    assign too_big  = lhs >= rhs;

    assign dcmp     = {1'b0, dmag_reg};
    assign r2       = {rem_reg[REM_W-2:0], qn_reg[WORD_BITS-1]};
    assign ge       = r2 >= dcmp;
    assign rem_next = ge ? r2 - dcmp : r2;
    assign qn_next  = {qn_reg[WORD_BITS-2:0], ge};
    assign round_up = {rem_reg[REM_W-2:0], 1'b0} >= dcmp;
    assign qr       = qn_reg + {{(WORD_BITS - 1){1'b0}}, round_up};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST && second_reg)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (act_reg == m2a_pkg::ACT_INV && sum_reg != '0)
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                state_next = too_big ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_reg    <= act;
                    a_reg      <= a;
                    b_reg      <= b;
                    x1_reg     <= x1;
                    y1_reg     <= y1;
                    neg1_reg   <= x1[WORD_BITS-1] ^ y1[WORD_BITS-1] ^ sub;
                    srcmag_reg <= mag(src);
                    srcneg_reg <= src_neg;
                    opclip_reg <= opclip;
                    mcand_reg  <= mag(x0);
                    mplier_reg <= TW'(mag(y0));
                    pneg_reg   <= x0[WORD_BITS-1] ^ y0[WORD_BITS-1];
                    macc_reg   <= '0;
                    sum_reg    <= '0;
                    cnt_reg    <= '0;
                    second_reg <= 1'b0;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    sum_reg    <= sum_next;
                    macc_reg   <= '0;
                    cnt_reg    <= '0;
                    second_reg <= 1'b1;
                    mcand_reg  <= mag(x1_reg);
                    mplier_reg <= TW'(mag(y1_reg));
                    pneg_reg   <= neg1_reg;
                end
                else
                begin
                    macc_reg   <= macc_next;
                    mplier_reg <= mplier_reg >> CHUNK;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                res_reg  <= a_reg;
                clip_reg <= 1'b0;
                sing_reg <= 1'b0;
                case (act_reg)
                    m2a_pkg::ACT_LOAD:
                    begin
                        res_reg  <= b_reg;
                        clip_reg <= opclip_reg;
                    end
                    m2a_pkg::ACT_ADD, m2a_pkg::ACT_SUB:
                    begin
                        res_reg  <= sat_add[WORD_BITS-1:0];
                        clip_reg <= sat_add[WORD_BITS];
                    end
                    m2a_pkg::ACT_SCALE:
                    begin
                        res_reg  <= sat_rnd[WORD_BITS-1:0];
                        clip_reg <= sat_rnd[WORD_BITS] | opclip_reg;
                    end
                    m2a_pkg::ACT_MUL:
                    begin
                        res_reg  <= sat_rnd[WORD_BITS-1:0];
                        clip_reg <= sat_rnd[WORD_BITS];
                    end
                    m2a_pkg::ACT_INV:
                    begin
                        sing_reg <= (sum_reg == '0);
                        dmag_reg <= dmag_c;
                        qneg_reg <= srcneg_reg ^ sum_reg[SW-1];
                    end
                    default:
                    begin
                        res_reg <= a_reg;
                    end
                endcase
            end
            ST_CMP:
            begin
                if (too_big)
                begin
                    res_reg  <= qneg_reg ? W_MIN : W_MAX;
                    clip_reg <= 1'b1;
                end
                else
                begin
                    rem_reg <= REM_W'(num >> WORD_BITS);
                    qn_reg  <= num[WORD_BITS-1:0];
                    cnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                qn_reg  <= qn_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_RND:
            begin
                res_reg <= qneg_reg ? -qr : qr;
            end
            default:
            begin
            end
        endcase
    end

    assign val       = res_reg;
    assign stat.done = (state_reg == ST_DONE);
    assign stat.clip = clip_reg;
    assign stat.sing = sing_reg;

endmodule

`default_nettype wire

>>> hdl/m2a_merge.sv
// Merge stage: holds the accumulator matrix and the result register, combines lane flags.
// Commits the four lane results together once every lane is done and the result slot is free.
// Depends on m2a_pkg for the result word and the lane status bundle.
`default_nettype none

module m2a_merge #(
    parameter int WORD_BITS = m2a_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [3:0][WORD_BITS-1:0]         lane_val,
    input  m2a_pkg::lane_stat_t [3:0]         lane_stat,
    input  logic                              res_ready,
    output logic [3:0][WORD_BITS-1:0]         acc,
    output logic                              res_valid,
    output m2a_pkg::res_t                     res,
    output logic                              commit
);

    logic [3:0][WORD_BITS-1:0] acc_reg;
    logic                      res_valid_reg;
    m2a_pkg::res_t             res_reg, res_next;
    logic                      all_done;

    assign all_done = lane_stat[0].done & lane_stat[1].done
                    & lane_stat[2].done & lane_stat[3].done;
    assign commit   = all_done && (!res_valid_reg || res_ready);

    always_comb
    begin
        res_next.r_r0c0    = 32'($signed(lane_val[0]));
        res_next.r_r0c1    = 32'($signed(lane_val[1]));
        res_next.r_r1c0    = 32'($signed(lane_val[2]));
        res_next.r_r1c1    = 32'($signed(lane_val[3]));
        res_next.saturated = lane_stat[0].clip | lane_stat[1].clip
                           | lane_stat[2].clip | lane_stat[3].clip;
        res_next.singular  = lane_stat[0].sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            acc_reg       <= lane_val;
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    assign acc       = acc_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> hdl/matrix2x2_accumulator_alu_unit.sv
// Top level of the 2x2 matrix accumulator unit: input saturation, operand routing, four lanes
// and the merge stage. Depends on m2a_pkg, m2a_lane and m2a_merge.
//
// Usage: the op channel (op_valid/op_ready/op) carries one word per operation on the signed
// fixed-point accumulator matrix: load, add, subtract, scale, matrix multiply or invert.
// Every accepted op word yields exactly one res word (res_valid/res_ready/res) holding the
// four updated elements and the saturated and singular flags.
// Each lane forms two chunked products and sums them; for invert it then checks the range and
// runs the restoring divide with a final rounding step. A singular invert finishes after the
// determinant and a clipping invert after the range check, both without the divide. One
// operation is in flight at a time; op_ready rises again in the cycle that the result is
// written into the output register, so no new op word is taken before then.
// Reset clears the accumulator to zero and empties the result register. When the receiver
// stalls, the result waits in the output register, the next op word is still accepted and
// computed, and that one is held in the lanes until the output register frees up.
`default_nettype none

module matrix2x2_accumulator_alu_unit #(
    parameter int WORD_BITS = m2a_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = m2a_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  m2a_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_ready,
    output m2a_pkg::res_t res
);

    localparam int EW = ((WORD_BITS > 32) ? WORD_BITS : 32) + 1;
    localparam logic signed [EW-1:0] E_MAX =
        {{(EW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [EW-1:0] E_MIN =
        {{(EW - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

    function automatic logic [WORD_BITS:0] in_sat(input logic [31:0] v);
        logic signed [EW-1:0] e;
        logic [WORD_BITS:0]   r;
        e = EW'($signed(v));
        if (e > E_MAX)
        begin
            r = {1'b1, E_MAX[WORD_BITS-1:0]};
        end
        else if (e < E_MIN)
        begin
            r = {1'b1, E_MIN[WORD_BITS-1:0]};
        end
        else
        begin
            r = {1'b0, e[WORD_BITS-1:0]};
        end
        return r;
    endfunction

    logic                        busy_reg;
    logic                        accept, commit, is_inv;
    logic [3:0][31:0]            b_in;
    logic [3:0][WORD_BITS:0]     b_sat;
    logic [3:0][WORD_BITS-1:0]   bs;
    logic [WORD_BITS:0]          k_sat;
    logic [3:0][WORD_BITS-1:0]   acc;
    logic [3:0][WORD_BITS-1:0]   lane_val;
    m2a_pkg::lane_stat_t [3:0]   lane_stat;

    assign op_ready = !busy_reg;
    assign accept   = op_valid && op_ready;
    assign is_inv   = (op.action == m2a_pkg::ACT_INV);

    assign b_in[0] = op.b_r0c0;
    assign b_in[1] = op.b_r0c1;
    assign b_in[2] = op.b_r1c0;
    assign b_in[3] = op.b_r1c1;
    assign k_sat   = in_sat(op.scale_factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (commit)
        begin
            busy_reg <= 1'b0;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        localparam int   ROW     = i / 2;
        localparam int   COL     = i % 2;
        localparam int   SRC_IDX = (i == 0) ? 3 : ((i == 3) ? 0 : i);
        localparam logic FLIP    = (i == 1) || (i == 2);

        logic [WORD_BITS-1:0] x0, y0, x1, y1;
        logic                 opclip, src_neg;

        assign b_sat[i] = in_sat(b_in[i]);
        assign bs[i]    = b_sat[i][WORD_BITS-1:0];
        assign src_neg  = acc[SRC_IDX][WORD_BITS-1] ^ FLIP;

        always_comb
        begin
            x0     = '0;
            y0     = '0;
            x1     = '0;
            y1     = '0;
            opclip = 1'b0;
            case (op.action)
                m2a_pkg::ACT_LOAD:
                begin
                    opclip = b_sat[i][WORD_BITS] | k_sat[WORD_BITS];
                end
                m2a_pkg::ACT_SCALE:
                begin
                    x0     = acc[i];
                    y0     = k_sat[WORD_BITS-1:0];
                    opclip = k_sat[WORD_BITS];
                end
                m2a_pkg::ACT_MUL:
                begin
                    x0 = acc[2 * ROW];
                    y0 = bs[COL];
                    x1 = acc[2 * ROW + 1];
                    y1 = bs[2 + COL];
                end
                m2a_pkg::ACT_INV:
                begin
                    x0 = acc[0];
                    y0 = acc[3];
                    x1 = acc[1];
                    y1 = acc[2];
                end
                default:
                begin
                end
            endcase
        end

        m2a_lane #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (accept),
            .act     (op.action),
            .a       (acc[i]),
            .b       (bs[i]),
            .x0      (x0),
            .y0      (y0),
            .x1      (x1),
            .y1      (y1),
            .sub     (is_inv),
            .src     (acc[SRC_IDX]),
            .src_neg (src_neg),
            .opclip  (opclip),
            .commit  (commit),
            .val     (lane_val[i]),
            .stat    (lane_stat[i])
        );
    end

    m2a_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_val  (lane_val),
        .lane_stat (lane_stat),
        .res_ready (res_ready),
        .acc       (acc),
        .res_valid (res_valid),
        .res       (res),
        .commit    (commit)
    );

endmodule

`default_nettype wire

>>> hdl/m2a_checker.sv
// Port-level checker for the 2x2 matrix accumulator unit and the bind that attaches it.
// Depends on m2a_pkg for the word types and on matrix2x2_accumulator_alu_unit as bind target.
`default_nettype none

module m2a_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          op_valid,
    input logic          op_ready,
    input m2a_pkg::op_t  op,
    input logic          res_valid,
    input logic          res_ready,
    input m2a_pkg::res_t res
);

    // A waiting op word must stay put until it is accepted.
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |=> op_valid && $stable(op))
        else $error("op word changed while waiting");

    // A stalled result word must stay put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // Only one operation is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && op_ready |=> !op_ready)
        else $error("op word accepted while another is in flight");

    // A new result only appears at the end of an operation in flight.
    a_res_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!op_ready))
        else $error("result word without an operation in flight");

    // A singular inversion keeps the matrix, so nothing can be clipped.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.singular && res.saturated))
        else $error("singular and saturated both set");

endmodule

bind matrix2x2_accumulator_alu_unit m2a_checker u_m2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

>>> tb/m2a_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the 2x2 matrix accumulator unit. It predicts each result word from the
// op words that the unit accepts and compares it with what the unit returns. Depends on m2a_pkg.
module m2a_result_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    input  logic          op_ready,
    input  m2a_pkg::op_t  op,
    input  logic          res_valid,
    input  logic          res_ready,
    input  m2a_pkg::res_t res,
    output int            mismatches,
    output int            pending
);

    localparam int WB = m2a_pkg::WORD_BITS_DEF;
    localparam int FB = m2a_pkg::FRAC_BITS_DEF;

    typedef logic signed [127:0]  wide_t;
    typedef logic signed [WB-1:0] elem_t;

    localparam wide_t ELEM_MAX   = (128'sd1 <<< (WB - 1)) - 128'sd1;
    localparam wide_t ELEM_MIN   = -(128'sd1 <<< (WB - 1));
    localparam wide_t ROUND_HALF = 128'sd1 <<< (FB - 1);

    elem_t         acc_model [4];
    m2a_pkg::res_t due_results [$];
    m2a_pkg::res_t want;

    function automatic bit out_of_range(input wide_t v);
        return (v > ELEM_MAX) || (v < ELEM_MIN);
    endfunction

    function automatic elem_t clamp(input wide_t v);
        if (v > ELEM_MAX)
            return ELEM_MAX[WB-1:0];
        if (v < ELEM_MIN)
            return ELEM_MIN[WB-1:0];
        return v[WB-1:0];
    endfunction

    function automatic m2a_pkg::res_t apply_op(input m2a_pkg::op_t w);
        wide_t         bw [4];
        elem_t         bq [4];
        elem_t         nm [4];
        elem_t         src [4];
        wide_t         kw, v, sx, det;
        elem_t         kq;
        logic [127:0]  dmag, num, quo, rmd;
        bit            opclip, kclip, clip, sing, dneg, neg;
        int            i, j;
        m2a_pkg::res_t r;
        bw[0] = $signed(w.b_r0c0);
        bw[1] = $signed(w.b_r0c1);
        bw[2] = $signed(w.b_r1c0);
        bw[3] = $signed(w.b_r1c1);
        kw = $signed(w.scale_factor);
        opclip = 1'b0;
        for (i = 0; i < 4; i++)
        begin
            opclip |= out_of_range(bw[i]);
            bq[i] = clamp(bw[i]);
        end
        kclip = out_of_range(kw);
        kq = clamp(kw);
        clip = 1'b0;
        sing = 1'b0;
        nm = acc_model;
        case (w.action)
            m2a_pkg::ACT_LOAD:
            begin
                nm = bq;
                clip = opclip | kclip;
            end
            m2a_pkg::ACT_ADD, m2a_pkg::ACT_SUB:
            begin
                for (i = 0; i < 4; i++)
                begin
                    v = acc_model[i];
                    if (w.action == m2a_pkg::ACT_SUB)
                        v = v - bq[i];
                    else
                        v = v + bq[i];
                    clip |= out_of_range(v);
                    nm[i] = clamp(v);
                end
            end
            m2a_pkg::ACT_SCALE:
            begin
                clip = kclip;
                for (i = 0; i < 4; i++)
                begin
                    v = acc_model[i];
                    v = v * kq;
                    v = (v + ROUND_HALF) >>> FB;
                    clip |= out_of_range(v);
                    nm[i] = clamp(v);
                end
            end
            m2a_pkg::ACT_MUL:
            begin
                for (i = 0; i < 2; i++)
                begin
                    for (j = 0; j < 2; j++)
                    begin
                        v = acc_model[2*i];
                        v = v * bq[j];
                        sx = acc_model[2*i+1];
                        sx = sx * bq[2+j];
                        v = (v + sx + ROUND_HALF) >>> FB;
                        clip |= out_of_range(v);
                        nm[2*i+j] = clamp(v);
                    end
                end
            end
            m2a_pkg::ACT_INV:
            begin
                v = acc_model[0];
                v = v * acc_model[3];
                sx = acc_model[1];
                sx = sx * acc_model[2];
                det = v - sx;
                if (det == 0)
                begin
                    sing = 1'b1;
                end
                else
                begin
                    dneg = det < 0;
                    dmag = dneg ? -det : det;
                    src[0] = acc_model[3];
                    src[1] = acc_model[1];
                    src[2] = acc_model[2];
                    src[3] = acc_model[0];
                    for (i = 0; i < 4; i++)
                    begin
                        sx = src[i];
                        neg = (sx < 0) ^ (i == 1 || i == 2) ^ dneg;
                        num = (sx < 0) ? -sx : sx;
                        num = num << (2 * FB);
                        quo = num / dmag;
                        rmd = num % dmag;
                        if ((rmd << 1) >= dmag)
                            quo = quo + 1;
                        v = neg ? -$signed(quo) : $signed(quo);
                        clip |= out_of_range(v);
                        nm[i] = clamp(v);
                    end
                end
            end
            default:
            begin
                clip = 1'b0;
            end
        endcase
        acc_model = nm;
        r.r_r0c0    = nm[0][31:0];
        r.r_r0c1    = nm[1][31:0];
        r.r_r1c0    = nm[2][31:0];
        r.r_r1c1    = nm[3][31:0];
        r.saturated = clip;
        r.singular  = sing;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %h, wanted %h", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                acc_model[i] = '0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word %h with nothing outstanding", res));
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("r_r0c0", res.r_r0c0, want.r_r0c0);
                    compare_field("r_r0c1", res.r_r0c1, want.r_r0c1);
                    compare_field("r_r1c0", res.r_r1c0, want.r_r1c0);
                    compare_field("r_r1c1", res.r_r1c1, want.r_r1c1);
                    compare_field("saturated", res.saturated, want.saturated);
                    compare_field("singular", res.singular, want.singular);
                end
            end
            if (op_valid && op_ready)
                due_results.push_back(apply_op(op));
            pending <= due_results.size();
        end
    end

endmodule

>>> tb/matrix2x2_accumulator_alu_unit_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the 2x2 matrix accumulator unit: clock, reset, op stimulus and
// result back-pressure. Depends on m2a_pkg, the unit itself and m2a_result_checker.
module matrix2x2_accumulator_alu_unit_tb;

    localparam int          CYCLE_LIMIT  = 800000;
    localparam int          RANDOM_ITEMS = 1700;
    localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] Q_ALL_ONES   = 32'hFFFF_FFFF;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          op_valid  = 1'b0;
    logic          res_ready = 1'b0;
    m2a_pkg::op_t  op        = '0;
    logic          op_ready;
    logic          res_valid;
    m2a_pkg::res_t res;
    int            mismatches;
    int            pending;
    int            cycles    = 0;

    always #5 clk = ~clk;

    matrix2x2_accumulator_alu_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    m2a_result_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic m2a_pkg::op_t make_op(input logic [2:0] act, input logic [31:0] a00,
                                             input logic [31:0] a01, input logic [31:0] a10,
                                             input logic [31:0] a11, input logic [31:0] k);
        m2a_pkg::op_t w;
        w.action       = act;
        w.b_r0c0       = a00;
        w.b_r0c1       = a01;
        w.b_r1c0       = a10;
        w.b_r1c1       = a11;
        w.scale_factor = k;
        return w;
    endfunction

    function automatic logic [31:0] rand_fix();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            4:          return ($urandom_range(0, 16) - 8) << 16;
            5:          return $urandom_range(0, 511) - 256;
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ALL_ONES;
                    4:       return 32'd1;
                    default: return Q_ONE;
                endcase
            end
            default:    return $urandom();
        endcase
    endfunction

    function automatic m2a_pkg::op_t random_op();
        m2a_pkg::op_t w;
        int           pick;
        int           m;
        pick = $urandom_range(0, 99);
        if (pick < 16)
            w.action = m2a_pkg::ACT_LOAD;
        else if (pick < 30)
            w.action = m2a_pkg::ACT_ADD;
        else if (pick < 42)
            w.action = m2a_pkg::ACT_SUB;
        else if (pick < 58)
            w.action = m2a_pkg::ACT_SCALE;
        else if (pick < 76)
            w.action = m2a_pkg::ACT_MUL;
        else if (pick < 96)
            w.action = m2a_pkg::ACT_INV;
        else if (pick < 98)
            w.action = ACT_SPARE_LO;
        else
            w.action = ACT_SPARE_HI;
        w.b_r0c0       = rand_fix();
        w.b_r0c1       = rand_fix();
        w.b_r1c0       = rand_fix();
        w.b_r1c1       = rand_fix();
        w.scale_factor = rand_fix();
        if (w.action == m2a_pkg::ACT_LOAD && $urandom_range(0, 5) == 0)
        begin
            m = $urandom_range(0, 6) - 3;
            w.b_r1c0 = w.b_r0c0 * m;
            w.b_r1c1 = w.b_r0c1 * m;
        end
        return w;
    endfunction

    task automatic send_word(input m2a_pkg::op_t w);
        op_valid <= 1'b1;
        op       <= w;
        @(posedge clk);
        while (!op_ready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int n);
        op_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_empty();
        op_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : result_sink
        int mode;
        int left;
        int period;
        int tick;
        bit long_done;
        mode      = 0;
        left      = 0;
        period    = 2;
        tick      = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (left == 0)
            begin
                if (!long_done && tick >= 5000)
                    mode = 3;
                else if ($urandom_range(0, 19) == 0)
                    mode = 3;
                else
                    mode = $urandom_range(0, 2);
                if (mode == 3)
                begin
                    long_done = 1'b1;
                    left = $urandom_range(250, 400);
                end
                else
                begin
                    left = $urandom_range(20, 300);
                end
                period = $urandom_range(2, 7);
            end
            left--;
            case (mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= ($urandom_range(0, 99) < 60);
                2:       res_ready <= ((tick % period) == 0);
                default: res_ready <= 1'b0;
            endcase
        end
    end

    initial
    begin : stimulus
        int sent;
        int burst;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(ACT_SPARE_LO, Q_MAX, Q_MIN, Q_ONE, Q_ALL_ONES, Q_MIN));
        send_word(make_op(m2a_pkg::ACT_LOAD, Q_MAX, Q_MIN, '0, Q_ALL_ONES, Q_MIN));
        send_word(make_op(m2a_pkg::ACT_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0));
        send_word(make_op(m2a_pkg::ACT_SUB, Q_MIN, Q_MAX, Q_MIN, Q_MIN, '0));
        send_word(make_op(m2a_pkg::ACT_MUL, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        send_word(make_op(m2a_pkg::ACT_SCALE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        send_word(make_op(m2a_pkg::ACT_LOAD, Q_ONE, '0, '0, Q_ONE, '0));
        send_word(make_op(m2a_pkg::ACT_SCALE, '0, '0, '0, '0, 32'h0002_8000));
        send_word(make_op(m2a_pkg::ACT_SCALE, '0, '0, '0, '0, 32'hFFFF_0000));
        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(m2a_pkg::ACT_LOAD, Q_ONE, 32'h0002_0000, 32'h0003_0000,
                          32'h0004_0000, '0));
        send_word(make_op(m2a_pkg::ACT_MUL, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_8000,
                          32'h0002_0000, '0));
        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(m2a_pkg::ACT_LOAD, Q_ONE, 32'h0002_0000, 32'h0002_0000,
                          32'h0004_0000, '0));
        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(m2a_pkg::ACT_LOAD, 32'd1, Q_ALL_ONES, 32'd3, 32'hFFFF_FFFD, '0));
        send_word(make_op(m2a_pkg::ACT_SCALE, '0, '0, '0, '0, 32'h0000_8000));
        send_word(make_op(m2a_pkg::ACT_LOAD, 32'd1, '0, '0, 32'd1, '0));
        send_word(make_op(m2a_pkg::ACT_INV, '0, '0, '0, '0, '0));
        send_word(make_op(ACT_SPARE_HI, '0, '0, '0, '0, '0));
        send_word(make_op(m2a_pkg::ACT_ADD, '0, '0, '0, '0, Q_ALL_ONES));
        wait_empty();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send_word(random_op());
                sent++;
                if (sent % 250 == 0)
                    wait_empty();
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, ($urandom_range(0, 4) == 0) ? 50 : 6));
        end

        wait_empty();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/m2a_pkg.sv
hdl/m2a_lane.sv
hdl/m2a_merge.sv
hdl/matrix2x2_accumulator_alu_unit.sv
hdl/m2a_checker.sv
tb/m2a_result_checker.sv
tb/matrix2x2_accumulator_alu_unit_tb.sv
